>>> sv/quad_x_motor_mixer_assert.svh
// Assertion macros of the quad X motor mixer RTL.
`ifndef QUAD_X_MOTOR_MIXER_ASSERT_SVH
`define QUAD_X_MOTOR_MIXER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define QXMM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quad_x_motor_mixer: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define QXMM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quad_x_motor_mixer: next-cycle check failed");

`endif

>>> sv/qxmm_pkg.sv
// Shared types and constants of the quad X motor mixer.
`default_nettype none
package qxmm_pkg;

	localparam int NUM_MOTORS = 4;
	localparam int CMD_W      = 8;
	localparam int TERM_W     = 11;
	localparam int SUM_W      = 15;

	localparam logic [1:0] REQ_MIX  = 2'd0;
	localparam logic [1:0] REQ_STOP = 2'd1;
	localparam logic [1:0] REQ_TEST = 2'd2;

	localparam logic [1:0] CFG_MAX_COMMAND  = 2'd0;
	localparam logic [1:0] CFG_THR_RESERVE  = 2'd1;
	localparam logic [1:0] CFG_IDLE_COMMAND = 2'd2;
	localparam logic [1:0] CFG_MIN_COMMAND  = 2'd3;

	localparam logic [CMD_W-1:0] RST_MAX_COMMAND  = 8'd255;
	localparam logic [CMD_W-1:0] RST_THR_RESERVE  = 8'd50;
	localparam logic [CMD_W-1:0] RST_IDLE_COMMAND = 8'd20;
	localparam logic [CMD_W-1:0] RST_MIN_COMMAND  = 8'd0;

	typedef struct packed {
		logic [CMD_W-1:0] max_command;
		logic [CMD_W-1:0] thr_reserve;
		logic [CMD_W-1:0] idle_command;
		logic [CMD_W-1:0] min_command;
	} cfg_t;

	typedef logic [NUM_MOTORS-1:0][CMD_W-1:0] cmd_arr_t;

endpackage
`default_nettype wire

>>> sv/quad_x_motor_mixer.sv
// Top level of the quad X motor mixer: input stage, command registers, outputs.
// An accepted request waits in the input register until the command register can take it.
// Throughput: one request per cycle if no result is held; else only an empty input fills.
// The command update is one pass of logic between the input register and the
// command register, which also serves as the output register.
// Reset: config registers take defaults, valid flags clear, all four commands clear to zero.
`default_nettype none
`include "quad_x_motor_mixer_assert.svh"
module quad_x_motor_mixer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [7:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic signed [10:0] throttle,
	input  wire logic signed [10:0] roll_term,
	input  wire logic signed [10:0] pitch_term,
	input  wire logic signed [10:0] yaw_term,
	input  wire logic [2:0]         motor_index,
	input  wire logic [7:0]         test_speed,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              cmd_front_right,
	output logic [7:0]              cmd_rear_left,
	output logic [7:0]              cmd_front_left,
	output logic [7:0]              cmd_rear_right,
	output logic [7:0]              duty_front_right,
	output logic [7:0]              duty_rear_left,
	output logic [7:0]              duty_front_left,
	output logic [7:0]              duty_rear_right
);
	import qxmm_pkg::*;

	cfg_t                     cfg;
	logic                     valid_s1;
	logic [1:0]               req_s1;
	logic signed [TERM_W-1:0] thr_s1, roll_s1, pitch_s1, yaw_s1;
	logic [2:0]               idx_s1;
	logic [CMD_W-1:0]         speed_s1;
	cmd_arr_t                 cmd_q;
	cmd_arr_t                 cmd_next;
	logic                     out_valid_q;
	logic                     advance;

	qxmm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	qxmm_update u_update (
		.cfg         (cfg),
		.req_type    (req_s1),
		.throttle    (thr_s1),
		.roll_term   (roll_s1),
		.pitch_term  (pitch_s1),
		.yaw_term    (yaw_s1),
		.motor_index (idx_s1),
		.test_speed  (speed_s1),
		.cmd_cur     (cmd_q),
		.cmd_next    (cmd_next)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1   <= req_type;
			thr_s1   <= throttle;
			roll_s1  <= roll_term;
			pitch_s1 <= pitch_term;
			yaw_s1   <= yaw_term;
			idx_s1   <= motor_index;
			speed_s1 <= test_speed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				cmd_q <= cmd_next;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign cmd_front_right  = cmd_q[0];
	assign cmd_rear_left    = cmd_q[1];
	assign cmd_front_left   = cmd_q[2];
	assign cmd_rear_right   = cmd_q[3];
	assign duty_front_right = cmd_q[0];
	assign duty_rear_left   = cmd_q[1];
	assign duty_front_left  = cmd_q[2];
	assign duty_rear_right  = cmd_q[3];

	`QXMM_ASSERT_NEXT(a_advance_gives_result, advance, out_valid_q)
	`QXMM_ASSERT_NEXT(a_cmds_hold_without_advance, !advance, $stable(cmd_q))
	`QXMM_ASSERT_NOW(a_full_and_stalled_blocks_input,
		valid_s1 && out_valid_q && !out_ready, !in_ready)

endmodule
`default_nettype wire

>>> sv/qxmm_cfg.sv
// Configuration register file of the quad X motor mixer.
`default_nettype none
module qxmm_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	output qxmm_pkg::cfg_t         cfg
);
	import qxmm_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_command  <= RST_MAX_COMMAND;
			cfg_q.thr_reserve  <= RST_THR_RESERVE;
			cfg_q.idle_command <= RST_IDLE_COMMAND;
			cfg_q.min_command  <= RST_MIN_COMMAND;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_COMMAND:  cfg_q.max_command  <= cfg_data;
				CFG_THR_RESERVE:  cfg_q.thr_reserve  <= cfg_data;
				CFG_IDLE_COMMAND: cfg_q.idle_command <= cfg_data;
				CFG_MIN_COMMAND:  cfg_q.min_command  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/qxmm_update.sv
// Next-command logic: mix, stop and single-motor test requests; other request types keep the commands.
`default_nettype none
module qxmm_update (
	input  wire qxmm_pkg::cfg_t          cfg,
	input  wire logic [1:0]              req_type,
	input  wire logic signed [10:0]      throttle,
	input  wire logic signed [10:0]      roll_term,
	input  wire logic signed [10:0]      pitch_term,
	input  wire logic signed [10:0]      yaw_term,
	input  wire logic [2:0]              motor_index,
	input  wire logic [7:0]              test_speed,
	input  wire qxmm_pkg::cmd_arr_t      cmd_cur,
	output qxmm_pkg::cmd_arr_t           cmd_next
);
	import qxmm_pkg::*;

	logic signed [TERM_W-1:0] cap;
	logic signed [TERM_W-1:0] thr;
	logic signed [SUM_W-1:0]  thr_x, roll_x, pitch_x, yaw_x, maxc_x, lo_x;
	logic signed [SUM_W-1:0]  sum [NUM_MOTORS];
	logic signed [SUM_W-1:0]  top_a, top_b, top;
	logic signed [SUM_W-1:0]  adj [NUM_MOTORS];
	logic [CMD_W-1:0]         lo;
	cmd_arr_t                 mix_cmd;

	always_comb begin
		cap = $signed({3'b000, cfg.max_command}) - $signed({3'b000, cfg.thr_reserve});
		if (throttle[TERM_W-1]) begin
			thr = '0;
		end else if (throttle > cap) begin
			thr = cap;
		end else begin
			thr = throttle;
		end

		thr_x   = {{(SUM_W-TERM_W){thr[TERM_W-1]}}, thr};
		roll_x  = {{(SUM_W-TERM_W){roll_term[TERM_W-1]}}, roll_term};
		pitch_x = {{(SUM_W-TERM_W){pitch_term[TERM_W-1]}}, pitch_term};
		yaw_x   = {{(SUM_W-TERM_W){yaw_term[TERM_W-1]}}, yaw_term};
		maxc_x  = $signed({{(SUM_W-CMD_W){1'b0}}, cfg.max_command});

		sum[0] = thr_x - roll_x - pitch_x + yaw_x;
		sum[1] = thr_x + roll_x + pitch_x + yaw_x;
		sum[2] = thr_x + roll_x - pitch_x - yaw_x;
		sum[3] = thr_x - roll_x + pitch_x - yaw_x;

		top_a = (sum[1] > sum[0]) ? sum[1] : sum[0];
		top_b = (sum[3] > sum[2]) ? sum[3] : sum[2];
		top   = (top_b > top_a) ? top_b : top_a;

		lo   = (thr > $signed({3'b000, cfg.idle_command})) ? cfg.idle_command
								       : cfg.min_command;
		lo_x = $signed({{(SUM_W-CMD_W){1'b0}}, lo});

		for (int i = 0; i < NUM_MOTORS; i++) begin
			adj[i] = (top > maxc_x) ? (sum[i] - top + maxc_x) : sum[i];
			if (adj[i] < lo_x) begin
				mix_cmd[i] = lo;
			end else if (adj[i] > maxc_x) begin
				mix_cmd[i] = cfg.max_command;
			end else begin
				mix_cmd[i] = adj[i][CMD_W-1:0];
			end
		end

		cmd_next = cmd_cur;
		case (req_type)
			REQ_MIX:  cmd_next = mix_cmd;
			REQ_STOP: cmd_next = '0;
			REQ_TEST: begin
				if (!motor_index[2]) begin
					cmd_next[motor_index[1:0]] = test_speed;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> bench/quad_x_motor_mixer_tb.sv
// Self-checking testbench for the quad X motor mixer: directed table, then random phases.
module quad_x_motor_mixer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qxmm_pkg::*;

	localparam logic [1:0] REQ_RESERVED = 2'd3;
	localparam logic [2:0] MOTOR_FR = 3'd0;
	localparam logic [2:0] MOTOR_RL = 3'd1;
	localparam logic [2:0] MOTOR_FL = 3'd2;
	localparam logic [2:0] MOTOR_RR = 3'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS = 145;
	localparam int QUIET_ITEMS = 100;

	typedef struct {
		logic [1:0]         kind;
		logic signed [10:0] throttle;
		logic signed [10:0] roll;
		logic signed [10:0] pitch;
		logic signed [10:0] yaw;
		logic [2:0]         motor;
		logic [7:0]         speed;
	} mixer_req_t;

	typedef struct {
		mixer_req_t req;
		bit         typed;
		cmd_arr_t   want;
	} table_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] cmd_front_right;
	logic [7:0] cmd_rear_left;
	logic [7:0] cmd_front_left;
	logic [7:0] cmd_rear_right;
	logic [7:0] duty_front_right;
	logic [7:0] duty_rear_left;
	logic [7:0] duty_front_left;
	logic [7:0] duty_rear_right;

	mixer_req_t drv_req;
	bit         row_typed;
	cmd_arr_t   row_want;

	logic [7:0] lim_max;
	logic [7:0] lim_headroom;
	logic [7:0] lim_idle;
	logic [7:0] lim_min;
	cmd_arr_t   mixer_cmd;
	cmd_arr_t   expected_cmds [$];
	table_row_t stimulus_table [$];

	int  fail_count;
	int  items_sent;
	int  results_seen;
	int  cycle_count;
	int  stall_left;
	bit  idle_on;

	quad_x_motor_mixer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (drv_req.kind),
		.throttle        (drv_req.throttle),
		.roll_term       (drv_req.roll),
		.pitch_term      (drv_req.pitch),
		.yaw_term        (drv_req.yaw),
		.motor_index     (drv_req.motor),
		.test_speed      (drv_req.speed),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cmd_front_right (cmd_front_right),
		.cmd_rear_left   (cmd_rear_left),
		.cmd_front_left  (cmd_front_left),
		.cmd_rear_right  (cmd_rear_right),
		.duty_front_right(duty_front_right),
		.duty_rear_left  (duty_rear_left),
		.duty_front_left (duty_front_left),
		.duty_rear_right (duty_rear_right)
	);

	always #5 clk = ~clk;

	function automatic int clamp_range(input int x, input int lo, input int hi);
		if (x < lo)
			return lo;
		if (x > hi)
			return hi;
		return x;
	endfunction

	function automatic cmd_arr_t motor_set(input logic [7:0] fr, input logic [7:0] rl,
		input logic [7:0] fl, input logic [7:0] rr);
		cmd_arr_t c;
		c[0] = fr;
		c[1] = rl;
		c[2] = fl;
		c[3] = rr;
		return c;
	endfunction

	// Updates the predicted motor commands for one accepted request.
	function automatic void advance_commands(input mixer_req_t r);
		int thr;
		int rl;
		int pt;
		int yw;
		int top;
		int floor_cmd;
		int sum [4];
		if (r.kind == REQ_MIX) begin
			rl = int'(r.roll);
			pt = int'(r.pitch);
			yw = int'(r.yaw);
			thr = clamp_range(int'(r.throttle), 0, int'(lim_max) - int'(lim_headroom));
			sum[0] = thr - rl - pt + yw;
			sum[1] = thr + rl + pt + yw;
			sum[2] = thr + rl - pt - yw;
			sum[3] = thr - rl + pt - yw;
			top = sum[0];
			for (int i = 1; i < 4; i++)
				if (sum[i] > top)
					top = sum[i];
			if (top > int'(lim_max))
				for (int i = 0; i < 4; i++)
					sum[i] -= top - int'(lim_max);
			floor_cmd = (thr > int'(lim_idle)) ? int'(lim_idle) : int'(lim_min);
			for (int i = 0; i < 4; i++)
				mixer_cmd[i] = 8'(clamp_range(sum[i], floor_cmd, int'(lim_max)));
		end else if (r.kind == REQ_STOP) begin
			mixer_cmd = '0;
		end else if (r.kind == REQ_TEST) begin
			if (r.motor < 3'd4)
				mixer_cmd[r.motor[1:0]] = r.speed;
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic mixer_req_t make_req(input logic [1:0] kind, input int thr,
		input int rl, input int pt, input int yw, input logic [2:0] motor,
		input logic [7:0] speed);
		mixer_req_t r;
		r.kind = kind;
		r.throttle = 11'(thr);
		r.roll = 11'(rl);
		r.pitch = 11'(pt);
		r.yaw = 11'(yw);
		r.motor = motor;
		r.speed = speed;
		return r;
	endfunction

	function automatic void add_row(input mixer_req_t r, input bit typed, input cmd_arr_t want);
		table_row_t row;
		row.req = r;
		row.typed = typed;
		row.want = want;
		stimulus_table.push_back(row);
	endfunction

	function automatic mixer_req_t random_req();
		mixer_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			r.kind = REQ_MIX;
		else if (pick < 70)
			r.kind = REQ_STOP;
		else if (pick < 92)
			r.kind = REQ_TEST;
		else
			r.kind = REQ_RESERVED;
		if ($urandom_range(0, 2) == 0) begin
			r.throttle = 11'($urandom);
			r.roll = 11'($urandom);
			r.pitch = 11'($urandom);
			r.yaw = 11'($urandom);
		end else begin
			r.throttle = 11'(int'($urandom_range(0, 320)) - 20);
			r.roll = 11'(int'($urandom_range(0, 160)) - 80);
			r.pitch = 11'(int'($urandom_range(0, 160)) - 80);
			r.yaw = 11'(int'($urandom_range(0, 160)) - 80);
		end
		r.motor = 3'($urandom);
		r.speed = 8'($urandom);
		return r;
	endfunction

	task automatic send_req(input mixer_req_t r, input bit typed, input cmd_arr_t want);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		drv_req <= r;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		while (results_seen < items_sent)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_limits(input logic [7:0] max_v, input logic [7:0] head_v,
		input logic [7:0] idle_v, input logic [7:0] min_v);
		in_valid <= 1'b0;
		drain();
		write_register(CFG_MAX_COMMAND, max_v);
		write_register(CFG_THR_RESERVE, head_v);
		write_register(CFG_IDLE_COMMAND, idle_v);
		write_register(CFG_MIN_COMMAND, min_v);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		cmd_arr_t want;
		if (in_valid && in_ready) begin
			advance_commands(drv_req);
			expected_cmds.push_back(row_typed ? row_want : mixer_cmd);
		end
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_COMMAND:  lim_max = cfg_data;
				CFG_THR_RESERVE:  lim_headroom = cfg_data;
				CFG_IDLE_COMMAND: lim_idle = cfg_data;
				CFG_MIN_COMMAND:  lim_min = cfg_data;
				default:          ;
			endcase
		end
		if (out_valid && out_ready) begin
			results_seen++;
			if (expected_cmds.size() == 0) begin
				$error("result transaction arrived with no expected commands");
				fail_count++;
			end else begin
				want = expected_cmds.pop_front();
				check_field("cmd_front_right", want[0], cmd_front_right);
				check_field("cmd_rear_left", want[1], cmd_rear_left);
				check_field("cmd_front_left", want[2], cmd_front_left);
				check_field("cmd_rear_right", want[3], cmd_rear_right);
				check_field("duty_front_right", want[0], duty_front_right);
				check_field("duty_rear_left", want[1], duty_rear_left);
				check_field("duty_front_left", want[2], duty_front_left);
				check_field("duty_rear_right", want[3], duty_rear_right);
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= (stall_left == 0);
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 11);
			out_ready <= 1'b0;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b1;
		drv_req = make_req(REQ_MIX, 0, 0, 0, 0, 3'd0, 8'd0);
		row_typed = 1'b0;
		row_want = '0;
		lim_max = RST_MAX_COMMAND;
		lim_headroom = RST_THR_RESERVE;
		lim_idle = RST_IDLE_COMMAND;
		lim_min = RST_MIN_COMMAND;
		mixer_cmd = '0;
		fail_count = 0;
		items_sent = 0;
		results_seen = 0;
		stall_left = 0;
		idle_on = 1'b1;

		add_row(make_req(REQ_RESERVED, 0, 0, 0, 0, 3'd0, 8'd0), 1, motor_set(0, 0, 0, 0));
		add_row(make_req(REQ_MIX, 0, 0, 0, 0, 3'd0, 8'd0), 1, motor_set(0, 0, 0, 0));
		add_row(make_req(REQ_MIX, 1023, 0, 0, 0, 3'd0, 8'd0), 1,
			motor_set(205, 205, 205, 205));
		add_row(make_req(REQ_MIX, -1024, 0, 0, 0, 3'd0, 8'd0), 1, motor_set(0, 0, 0, 0));
		add_row(make_req(REQ_MIX, 200, 0, 0, 100, 3'd0, 8'd0), 1,
			motor_set(255, 255, 55, 55));
		add_row(make_req(REQ_MIX, 10, 500, 0, 0, 3'd0, 8'd0), 1, motor_set(0, 255, 255, 0));
		add_row(make_req(REQ_MIX, 20, 0, 30, 0, 3'd0, 8'd0), 1, motor_set(0, 50, 0, 50));
		add_row(make_req(REQ_MIX, 21, 0, 30, 0, 3'd0, 8'd0), 1, motor_set(20, 51, 20, 51));
		add_row(make_req(REQ_MIX, 1023, 1023, -1024, 1023, 3'd7, 8'd255), 0, '0);
		add_row(make_req(REQ_MIX, -1, -1024, 1023, -1024, 3'd0, 8'd0), 0, '0);
		add_row(make_req(REQ_MIX, 100, -1, -1, -1, 3'd0, 8'd0), 0, '0);
		add_row(make_req(REQ_STOP, 1023, 1023, 1023, 1023, 3'd7, 8'd255), 1,
			motor_set(0, 0, 0, 0));
		add_row(make_req(REQ_TEST, 0, 0, 0, 0, MOTOR_FR, 8'd255), 1, motor_set(255, 0, 0, 0));
		add_row(make_req(REQ_TEST, 0, 0, 0, 0, MOTOR_RL, 8'd128), 1,
			motor_set(255, 128, 0, 0));
		add_row(make_req(REQ_TEST, 0, 0, 0, 0, MOTOR_FL, 8'd1), 1, motor_set(255, 128, 1, 0));
		add_row(make_req(REQ_TEST, 0, 0, 0, 0, MOTOR_RR, 8'd170), 1,
			motor_set(255, 128, 1, 170));
		add_row(make_req(REQ_TEST, 0, 0, 0, 0, 3'd4, 8'd99), 1, motor_set(255, 128, 1, 170));
		add_row(make_req(REQ_TEST, -1024, 0, 0, 0, 3'd7, 8'd0), 1,
			motor_set(255, 128, 1, 170));
		add_row(make_req(REQ_RESERVED, 500, 7, -7, 3, MOTOR_FL, 8'd33), 1,
			motor_set(255, 128, 1, 170));
		add_row(make_req(REQ_TEST, 0, 0, 0, 0, MOTOR_RR, 8'd0), 1, motor_set(255, 128, 1, 0));
		add_row(make_req(REQ_MIX, 1023, -1024, -1024, -1024, 3'd0, 8'd0), 0, '0);
		add_row(make_req(REQ_STOP, 0, 0, 0, 0, 3'd0, 8'd0), 1, motor_set(0, 0, 0, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stimulus_table[i])
			send_req(stimulus_table[i].req, stimulus_table[i].typed, stimulus_table[i].want);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0:       load_limits(8'd255, 8'd0, 8'd0, 8'd0);
				1:       load_limits(8'd0, 8'd255, 8'd255, 8'd255);
				2:       load_limits(8'd128, 8'd200, 8'd10, 8'd5);
				3:       load_limits(8'd200, 8'd40, 8'd30, 8'd60);
				4:       load_limits(8'd255, 8'd255, 8'd0, 8'd255);
				5:       load_limits(8'd0, 8'd0, 8'd0, 8'd0);
				default: load_limits(8'($urandom), 8'($urandom_range(0, 120)),
						8'($urandom_range(0, 80)), 8'($urandom_range(0, 60)));
			endcase
			idle_on = ($urandom_range(0, 3) != 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == RANDOM_PHASES - 1 && n >= PHASE_ITEMS - QUIET_ITEMS)
					idle_on = 1'b0;
				send_req(random_req(), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		drain();
		repeat (8) @(posedge clk);
		if (expected_cmds.size() != 0) begin
			$error("%0d expected result transactions never arrived", expected_cmds.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
